### hdl/lpr_pkg.sv
// lpr_pkg: shared types and codes of the ipv6 longest-prefix route table
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package lpr_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 16;
  localparam int unsigned PADDR_W         = 5;
  localparam logic [7:0]  FULL_LEN        = 8'd128;

  // request kinds
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_HIT      = 2'd0;
  localparam logic [1:0] STATUS_DEFAULT  = 2'd1;
  localparam logic [1:0] STATUS_INSERTED = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_DEF_HOP_HIGH = 5'd0;
  localparam logic [PADDR_W-1:0] REG_DEF_HOP_LOW  = 5'd8;
  localparam logic [PADDR_W-1:0] REG_DEF_PORT     = 5'd16;

  typedef struct packed {
    logic        req_type;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix_bits;
    logic [63:0] hop_high;
    logic [63:0] hop_low;
    logic [7:0]  port_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_pos;
    logic [63:0] out_hop_high;
    logic [63:0] out_hop_low;
    logic [7:0]  out_port;
  } rsp_t;

  typedef struct packed {
    logic [127:0] prefix;
    logic [7:0]   len;
    logic [127:0] hop;
    logic [7:0]   port;
  } entry_t;

endpackage

`default_nettype wire

### hdl/lpr_if.sv
// lpr_req_if / lpr_rsp_if: valid-ready channels of the route table
// depends on lpr_pkg for the payload types
`default_nettype none

interface lpr_req_if;
  logic           valid;
  logic           ready;
  lpr_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpr_rsp_if;
  logic           valid;
  logic           ready;
  lpr_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/lpr_match.sv
// lpr_match: masked 128-bit prefix compare shared by every lookup step
// depends on nothing but its ports
`default_nettype none

module lpr_match (
  input  logic [127:0] dest,
  input  logic [127:0] prefix,
  input  logic [7:0]   len,
  output logic         hit
);

  logic [127:0] mask;

  // bit 127 is the first bit of the address
  always_comb begin
    for (int j = 0; j < 128; j++) begin
      mask[127 - j] = (8'(j) < len);
    end
  end

  assign hit = (((dest ^ prefix) & mask) == '0);

endmodule

`default_nettype wire

### hdl/ipv6_longest_prefix_route_table.sv
// ipv6_longest_prefix_route_table: sorted ipv6 route table with lookup and insert
// depends on lpr_pkg, lpr_req_if, lpr_rsp_if and lpr_match
//
//   channel  dir  kind          carries
//   req      in   valid/ready   lookup destination or route to insert
//   rsp      out  valid/ready   status, position, next hop, interface
//   apb      in   psel/penable  default hop high/low (64) and default port (8)
//
// a lookup makes one memory read per stored route, in order, compared by the single
// masked compare unit, until a route decides it; an insert moves each route shorter
// than the new one up one slot through the one write port, then places the new one;
// a full table insert or an empty-table lookup finishes without a memory access
// reset (rst, synchronous) empties the table through the fill count, no sweep
// req is ready only in idle; a stalled rsp holds every lookup step and the finishing step in place
`default_nettype none

module ipv6_longest_prefix_route_table #(
  parameter int unsigned TABLE_ENTRIES = lpr_pkg::DEFAULT_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  lpr_req_if.sink                     req,
  lpr_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpr_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import lpr_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_SHIFT  = 5'b00100,
    ST_PLACE  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [IW-1:0] cur, cur_next;
  logic [CW-1:0] count, count_next;
  logic [1:0]    fin_code, fin_code_next;

  // the item in work: route to insert, or destination in prefix for a lookup
  entry_t        job;

  // route memory: one write port, one registered read port
  entry_t        mem [TABLE_ENTRIES];
  entry_t        rdata;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  // configuration registers
  logic [63:0]   def_hop_high, def_hop_low;
  logic [7:0]    def_port;

  // result register
  logic          out_valid;
  rsp_t          out_data;
  logic          emit;
  rsp_t          emit_data;
  logic          can_emit;

  logic          hit;
  logic          accept;
  logic [7:0]    len_sat;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      def_hop_high <= '0;
      def_hop_low  <= '0;
      def_port     <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_DEF_HOP_HIGH: def_hop_high <= pwdata;
        REG_DEF_HOP_LOW:  def_hop_low  <= pwdata;
        REG_DEF_PORT:     def_port     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_DEF_HOP_HIGH: prdata = def_hop_high;
      REG_DEF_HOP_LOW:  prdata = def_hop_low;
      REG_DEF_PORT:     prdata = {56'd0, def_port};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared masked compare: destination against the route just read
  // ---------------------------------------------------------------------------
  lpr_match u_match (
    .dest   (job.prefix),
    .prefix (rdata.prefix),
    .len    (rdata.len),
    .hit    (hit)
  );

  // ---------------------------------------------------------------------------
  // memory
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign can_emit  = !out_valid || rsp.ready;
  assign len_sat   = (req.data.prefix_bits > FULL_LEN) ? FULL_LEN : req.data.prefix_bits;

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    count_next    = count;
    fin_code_next = fin_code;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = cur;
    wr_data       = job;
    emit          = 1'b0;
    emit_data     = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.data.req_type == REQ_INSERT) begin
            if (count == CW'(TABLE_ENTRIES)) begin
              fin_code_next = STATUS_FULL;
              state_next    = ST_FINISH;
            end else if (count == '0) begin
              cur_next   = '0;
              state_next = ST_PLACE;
            end else begin
              // walk down from the top, moving shorter routes up a slot
              cur_next   = IW'(count);
              rd_en      = 1'b1;
              rd_addr    = IW'(count - CW'(1));
              state_next = ST_SHIFT;
            end
          end else begin
            if (count == '0) begin
              fin_code_next = STATUS_DEFAULT;
              state_next    = ST_FINISH;
            end else begin
              cur_next   = '0;
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_next = ST_LOOKUP;
            end
          end
        end
      end
      ST_LOOKUP: begin
        // rdata holds route cur
        if (can_emit) begin
          if (rdata.len == '0) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end else if (hit) begin
            emit = 1'b1;
            emit_data.status       = STATUS_HIT;
            emit_data.entry_pos    = 4'(cur);
            emit_data.out_hop_high = rdata.hop[127:64];
            emit_data.out_hop_low  = rdata.hop[63:0];
            emit_data.out_port     = rdata.port;
            state_next = ST_IDLE;
          end else if ((CW'(cur) + CW'(1)) == count) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cur_next = cur + IW'(1);
            rd_en    = 1'b1;
            rd_addr  = cur + IW'(1);
          end
          // miss paths and a zero-length route fall back to the default route
          if (emit && (state_next == ST_IDLE) && !(hit && rdata.len != '0)) begin
            emit_data.status       = STATUS_DEFAULT;
            emit_data.out_hop_high = def_hop_high;
            emit_data.out_hop_low  = def_hop_low;
            emit_data.out_port     = def_port;
          end
        end
      end
      ST_SHIFT: begin
        // rdata holds route cur-1
        if (rdata.len < job.len) begin
          wr_en    = 1'b1;
          wr_addr  = cur;
          wr_data  = rdata;
          cur_next = cur - IW'(1);
          if (cur == IW'(1)) begin
            state_next = ST_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cur - IW'(2);
          end
        end else if (can_emit) begin
          wr_en            = 1'b1;
          wr_addr          = cur;
          count_next       = count + CW'(1);
          emit             = 1'b1;
          emit_data.status = STATUS_INSERTED;
          state_next       = ST_IDLE;
        end
      end
      ST_PLACE: begin
        if (can_emit) begin
          wr_en            = 1'b1;
          wr_addr          = cur;
          count_next       = count + CW'(1);
          emit             = 1'b1;
          emit_data.status = STATUS_INSERTED;
          state_next       = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (can_emit) begin
          emit             = 1'b1;
          emit_data.status = fin_code;
          if (fin_code == STATUS_DEFAULT) begin
            emit_data.out_hop_high = def_hop_high;
            emit_data.out_hop_low  = def_hop_low;
            emit_data.out_port     = def_port;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cur       <= '0;
      fin_code  <= STATUS_DEFAULT;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cur      <= cur_next;
      fin_code <= fin_code_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      job.prefix <= {req.data.addr_high, req.data.addr_low};
      job.len    <= len_sat;
      job.hop    <= {req.data.hop_high, req.data.hop_low};
      job.port   <= req.data.port_in;
    end
    if (emit) begin
      out_data <= emit_data;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

`default_nettype wire

### hdl/lpr_checker.sv
// lpr_checker: port-level assertions on the route table, bound to the top level
// depends on lpr_pkg and ipv6_longest_prefix_route_table
`default_nettype none

module lpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [3:0]  rsp_entry_pos,
  input logic [63:0] rsp_hop_high,
  input logic [63:0] rsp_hop_low,
  input logic [7:0]  rsp_port
);
  import lpr_pkg::*;

  // a result waiting for its sink stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp dropped while stalled");

  // every request leaves the idle state, so ready drops after a transfer
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req ready right after a transfer");

  a_insert_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STATUS_INSERTED) |->
      (rsp_entry_pos == '0) && (rsp_hop_high == '0) && (rsp_hop_low == '0) &&
      (rsp_port == '0))
    else $error("insert result carries data");

  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STATUS_FULL) |->
      (rsp_entry_pos == '0) && (rsp_hop_high == '0) && (rsp_hop_low == '0) &&
      (rsp_port == '0))
    else $error("table full result carries data");

  a_default_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STATUS_DEFAULT) |-> (rsp_entry_pos == '0))
    else $error("default result with a position");

endmodule

bind ipv6_longest_prefix_route_table lpr_checker u_lpr_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.data.status),
  .rsp_entry_pos (rsp.data.entry_pos),
  .rsp_hop_high  (rsp.data.out_hop_high),
  .rsp_hop_low   (rsp.data.out_hop_low),
  .rsp_port      (rsp.data.out_port)
);

`default_nettype wire
